/* sv/jpeg_marker_scanner_top_assert.svh */
// assertion macros for the jpeg marker scanner
// used by jpeg_marker_scanner_top; expects clk and rst_n in scope
`ifndef JPEG_MARKER_SCANNER_TOP_ASSERT_SVH
`define JPEG_MARKER_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jpeg marker scanner: same-cycle check failed");

// next-cycle implication, checked outside reset
`define JMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jpeg marker scanner: next-cycle check failed");

`endif

/* sv/jms_pkg.sv */
// shared types and constants for the jpeg marker scanner
// no dependencies
package jms_pkg;

    localparam int POS_BITS = 24;
    localparam int OUT_BITS = 24;
    localparam int LEN_BITS = 16;
    localparam int SUM_BITS = ((POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS) + 1;
    localparam int NUM_OFFSETS = 9;
    localparam int RES_BITS = NUM_OFFSETS * OUT_BITS;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [7:0] MK_FILL   = 8'hFF;
    localparam logic [7:0] MK_STUFF  = 8'h00;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_DQT    = 8'hDB;
    localparam logic [7:0] MK_APP0   = 8'hE0;
    localparam logic [7:0] MK_APP1   = 8'hE1;

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_HUNT,
        PH_FFRUN,
        PH_LENHI,
        PH_LENLO,
        PH_SKIP,
        PH_TRAIL,
        PH_TRAILFF,
        PH_DONE,
        PH_FAIL
    } phase_t;

endpackage

/* sv/jpeg_marker_scanner_top.sv */
// jpeg marker scanner: byte stream in, one offset summary per buffer out
// depends on jms_pkg and jpeg_marker_scanner_top_assert.svh
//
// channel  dir  width  content
// s_axis   in   8+1+1  tdata data_byte, tlast last_byte, tuser headers_only
// m_axis   out  216+1  tdata nine offsets, tuser status
//
// one beat per cycle on s_axis unless stalled as below; a result is valid once the
// beat carrying tlast has passed the input stage and then the result register
// the scan state updates from the input stage in a single pass per byte
// a stalled m_axis holds the result; s_axis keeps taking beats unless a
// second result would need the result register before it drains
// rst_n clears all scan state and empties both stages
module jpeg_marker_scanner_top
    import jms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // data_byte
    input  logic                s_axis_tlast,   // last_byte
    input  logic                s_axis_tuser,   // headers_only
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // field_size, quant_offset, huffman_offset, frame_header_offset, scan_offset,
    // entropy_data_offset, padded_length, app0_offset, app1_offset (24 bits each)
    output logic [RES_BITS-1:0] m_axis_tdata,
    output logic                m_axis_tuser    // status
);

`include "jpeg_marker_scanner_top_assert.svh"

    // input stage
    logic                stage_valid_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;
    logic                hdr_reg;

    // scan state
    phase_t              phase_reg, phase_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [LEN_BITS-1:0] skip_reg, skip_next;
    logic [7:0]          lenhi_reg, lenhi_next;
    logic [7:0]          marker_reg, marker_next;
    logic                stop_reg, stop_next;
    logic [OUT_BITS-1:0] end_reg, end_next;
    logic [OUT_BITS-1:0] quant_reg, quant_next;
    logic [OUT_BITS-1:0] huff_reg, huff_next;
    logic [OUT_BITS-1:0] frame_reg, frame_next;
    logic [OUT_BITS-1:0] sos_reg, sos_next;
    logic [OUT_BITS-1:0] entropy_reg, entropy_next;
    logic [OUT_BITS-1:0] app0_reg, app0_next;
    logic [OUT_BITS-1:0] app1_reg, app1_next;
    logic [OUT_BITS-1:0] padded_reg, padded_next;

    // result register
    logic                out_valid_reg;
    logic                out_status_reg, out_status_next;
    logic [RES_BITS-1:0] out_data_reg, out_data_next;

    logic                advance;
    logic                emit;
    logic                ok;
    logic [LEN_BITS-1:0] seg_len;
    logic [SUM_BITS-1:0] sos_end;
    logic [OUT_BITS-1:0] at_off;
    logic                no_segment;

    // only a closing beat needs the result register free
    assign advance       = stage_valid_reg && (!last_reg || !out_valid_reg || m_axis_tready);
    assign emit          = advance && last_reg;
    assign s_axis_tready = !stage_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    assign seg_len    = {lenhi_reg, byte_reg};
    assign sos_end    = SUM_BITS'(pos_reg) - SUM_BITS'(1) + SUM_BITS'(seg_len);
    assign at_off     = OUT_BITS'(pos_reg - POS_BITS'(1));
    assign no_segment = (byte_reg == MK_STUFF) || (byte_reg == MK_TEM) ||
                        ((byte_reg >= MK_RST0) && (byte_reg <= MK_RST7));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            stage_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
            hdr_reg  <= s_axis_tuser;
        end
    end

    // per-byte scan step
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        lenhi_next   = lenhi_reg;
        marker_next  = marker_reg;
        stop_next    = (phase_reg == PH_SOI0) ? hdr_reg : stop_reg;
        end_next     = end_reg;
        quant_next   = quant_reg;
        huff_next    = huff_reg;
        frame_next   = frame_reg;
        sos_next     = sos_reg;
        entropy_next = entropy_reg;
        app0_next    = app0_reg;
        app1_next    = app1_reg;
        padded_next  = padded_reg;
        ok           = 1'b0;

        if (pos_reg == POS_MAX)
        begin
            phase_next = PH_FAIL;
        end
        else
        begin
            pos_next = pos_reg + POS_BITS'(1);
            unique case (phase_reg)
                PH_SOI0:
                    phase_next = (byte_reg == MK_FILL) ? PH_SOI1 : PH_FAIL;
                PH_SOI1:
                    phase_next = (byte_reg == MK_SOI) ? PH_HUNT : PH_FAIL;
                PH_HUNT:
                    if (byte_reg == MK_FILL)
                    begin
                        phase_next = PH_FFRUN;
                    end
                PH_FFRUN:
                    if (byte_reg != MK_FILL)
                    begin
                        marker_next = byte_reg;
                        if (byte_reg == MK_SOF0 || byte_reg == MK_SOF1)
                        begin
                            frame_next = at_off;
                        end
                        if (byte_reg == MK_DQT && quant_reg == '0)
                        begin
                            quant_next = at_off;
                        end
                        if (byte_reg == MK_DHT && huff_reg == '0)
                        begin
                            huff_next = at_off;
                        end
                        if (byte_reg == MK_SOS)
                        begin
                            sos_next = at_off;
                        end
                        if (byte_reg == MK_APP0 && app0_reg == '0)
                        begin
                            app0_next = at_off;
                        end
                        if (byte_reg == MK_APP1 && app1_reg == '0)
                        begin
                            app1_next = at_off;
                        end
                        priority if (byte_reg == MK_EOI)
                        begin
                            end_next   = OUT_BITS'(pos_reg + POS_BITS'(1));
                            phase_next = PH_TRAIL;
                        end
                        else if (no_segment)
                        begin
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            phase_next = PH_LENHI;
                        end
                    end
                PH_LENHI:
                begin
                    lenhi_next = byte_reg;
                    phase_next = PH_LENLO;
                end
                PH_LENLO:
                begin
                    if (marker_reg == MK_SOS)
                    begin
                        entropy_next = OUT_BITS'(sos_end);
                    end
                    priority if (marker_reg == MK_SOS && stop_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (seg_len < LEN_BITS'(2))
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        skip_next  = seg_len - LEN_BITS'(2);
                        phase_next = (seg_len == LEN_BITS'(2)) ? PH_HUNT : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - LEN_BITS'(1);
                    if (skip_reg == LEN_BITS'(1))
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_TRAIL:
                    if (byte_reg == MK_FILL)
                    begin
                        phase_next = PH_TRAILFF;
                    end
                PH_TRAILFF:
                    priority if (byte_reg == MK_SOI)
                    begin
                        padded_next = at_off;
                        phase_next  = PH_DONE;
                    end
                    else if (byte_reg != MK_FILL)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        phase_next = PH_TRAILFF;
                    end
                default:
                    phase_next = phase_reg;
            endcase
        end

        // closing decision on the final byte of a buffer
        priority if (phase_next == PH_DONE)
        begin
            ok = 1'b1;
        end
        else if (phase_next == PH_TRAIL || phase_next == PH_TRAILFF)
        begin
            padded_next = OUT_BITS'(pos_reg + POS_BITS'(1));
            ok          = 1'b1;
        end
        else if (phase_next == PH_LENHI && marker_next == MK_SOS && stop_next)
        begin
            entropy_next = OUT_BITS'(pos_reg + POS_BITS'(1));
            ok           = 1'b1;
        end
        else if (phase_next == PH_LENLO && marker_next == MK_SOS && stop_next)
        begin
            entropy_next = OUT_BITS'(pos_reg);
            ok           = 1'b1;
        end
        else
        begin
            ok = 1'b0;
        end

        out_status_next = !ok;
        out_data_next   = ok ? {app1_next, app0_next, padded_next, entropy_next, sos_next,
                                frame_next, huff_next, quant_next, end_next}
                             : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SOI0;
            pos_reg     <= '0;
            skip_reg    <= '0;
            lenhi_reg   <= '0;
            marker_reg  <= '0;
            stop_reg    <= 1'b0;
            end_reg     <= '0;
            quant_reg   <= '0;
            huff_reg    <= '0;
            frame_reg   <= '0;
            sos_reg     <= '0;
            entropy_reg <= '0;
            app0_reg    <= '0;
            app1_reg    <= '0;
            padded_reg  <= '0;
        end
        else if (emit)
        begin
            // buffer finished: back to the reset picture
            phase_reg   <= PH_SOI0;
            pos_reg     <= '0;
            skip_reg    <= '0;
            lenhi_reg   <= '0;
            marker_reg  <= '0;
            stop_reg    <= 1'b0;
            end_reg     <= '0;
            quant_reg   <= '0;
            huff_reg    <= '0;
            frame_reg   <= '0;
            sos_reg     <= '0;
            entropy_reg <= '0;
            app0_reg    <= '0;
            app1_reg    <= '0;
            padded_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            lenhi_reg   <= lenhi_next;
            marker_reg  <= marker_next;
            stop_reg    <= stop_next;
            end_reg     <= end_next;
            quant_reg   <= quant_next;
            huff_reg    <= huff_next;
            frame_reg   <= frame_next;
            sos_reg     <= sos_next;
            entropy_reg <= entropy_next;
            app0_reg    <= app0_next;
            app1_reg    <= app1_next;
            padded_reg  <= padded_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
        end
    end

    `JMS_ASSERT_SAME(a_error_clears_payload, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `JMS_ASSERT_NEXT(a_emit_restarts_scan, emit, phase_reg == PH_SOI0 && pos_reg == '0)
    `JMS_ASSERT_SAME(a_skip_nonzero, phase_reg == PH_SKIP, skip_reg != '0)
    `JMS_ASSERT_SAME(a_trail_has_end, phase_reg == PH_TRAIL || phase_reg == PH_TRAILFF,
                     end_reg != '0)

endmodule
